// File: hw/rtl/psdec_pkg.sv
// ----------------------------------------------------------------------------
// PostScript string decoder package
// Shared types, character codes and helper functions of the string decoder.
// ----------------------------------------------------------------------------
package psdec_pkg;

  // Deepest parenthesis nesting accepted inside a literal string.
  localparam int unsigned NEST_LIMIT = 255;
  localparam int unsigned DEPTH_W    = $clog2(NEST_LIMIT + 1);

  // Result queue between the decode stage and the output channel.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = QPTR_W + 1;

  typedef enum logic [2:0] {
    M_IDLE = 3'd0,
    M_LIT  = 3'd1,
    M_ESC  = 3'd2,
    M_OCT  = 3'd3,
    M_HEXH = 3'd4,
    M_HEXL = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_LINE = 2'd1,
    ST_HEX  = 2'd2,
    ST_DEEP = 2'd3
  } status_e;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  // Byte values of the named escapes.
  localparam logic [7:0] BS_BYTE = 8'd8;
  localparam logic [7:0] HT_BYTE = 8'd9;
  localparam logic [7:0] LF_BYTE = 8'd10;
  localparam logic [7:0] FF_BYTE = 8'd12;
  localparam logic [7:0] CR_BYTE = 8'd13;

  // Offsets that turn a hex letter into its nibble value.
  localparam logic [7:0] UHEX_OFS = CH_UA - 8'd10;
  localparam logic [7:0] LHEX_OFS = CH_LA - 8'd10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       string_end;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } nibble_t;

  function automatic result_t mk_res(logic [7:0] b, logic has, logic e, status_e s);
    result_t r;
    r.data_byte  = b;
    r.has_byte   = has;
    r.string_end = e;
    r.status     = s;
    return r;
  endfunction

  function automatic nibble_t nibble_of(logic [7:0] c);
    nibble_t n;
    n.ok  = 1'b1;
    n.val = c[3:0];
    if (c >= CH_ZERO && c <= CH_NINE) begin
      n.val = c[3:0];
    end else if (c >= CH_UA && c <= CH_UF) begin
      n.val = 4'(c - UHEX_OFS);
    end else if (c >= CH_LA && c <= CH_LF) begin
      n.val = 4'(c - LHEX_OFS);
    end else begin
      n.ok = 1'b0;
    end
    return n;
  endfunction

  function automatic logic is_white(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_octal(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_SEVEN);
  endfunction

endpackage

// File: hw/rtl/psdec_in_if.sv
// ----------------------------------------------------------------------------
// String decoder character channel
// Valid/ready channel that carries one source character or a line end.
// ----------------------------------------------------------------------------
interface psdec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       line_end;

  modport source (output valid, output char_in, output line_end, input ready);
  modport sink   (input valid, input char_in, input line_end, output ready);
endinterface

// File: hw/rtl/psdec_out_if.sv
// ----------------------------------------------------------------------------
// String decoder result channel
// Valid/ready channel that carries one decoded byte or string end marker.
// ----------------------------------------------------------------------------
interface psdec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       string_end;
  logic [1:0] status;

  modport source (output valid, output data_byte, output has_byte,
                  output string_end, output status, input ready);
  modport sink   (input valid, input data_byte, input has_byte,
                  input string_end, input status, output ready);
endinterface

// File: hw/rtl/psdec_step.sv
// ----------------------------------------------------------------------------
// String decoder step
// Input register, decoder state and the per-character decode logic that
// produces up to two results for the result queue.
// ----------------------------------------------------------------------------
module psdec_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  psdec_in_if.sink        in_i,
  input  logic            room_i,
  output psdec_pkg::push_t push_o
);
  import psdec_pkg::*;

  localparam logic [DEPTH_W-1:0] LIMIT_D = DEPTH_W'(NEST_LIMIT);

  logic               in_vld_q;
  logic [7:0]         char_q;
  logic               le_q;
  logic               fire;

  mode_e              mode_q, mode_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [7:0]         oct_val_q, oct_val_d;
  logic [1:0]         oct_cnt_q, oct_cnt_d;
  logic [3:0]         hnib_q, hnib_d;

  // Literal character handling, shared by the literal and octal modes.
  logic               lit_has;
  result_t            lit_res;
  mode_e              lit_mode;
  logic [DEPTH_W-1:0] lit_depth;
  logic               lit_idle;
  logic [DEPTH_W-1:0] dec_depth;

  logic               go_idle;
  nibble_t            nib;
  logic [7:0]         oct_next;
  logic [1:0]         oct_cnt_inc;
  push_t              push;

  assign fire       = in_vld_q && room_i;
  assign in_i.ready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      char_q <= in_i.char_in;
      le_q   <= in_i.line_end;
    end
  end

  assign dec_depth = (depth_q != '0) ? depth_q - DEPTH_W'(1) : '0;

  always_comb begin
    lit_has   = 1'b1;
    lit_res   = mk_res(char_q, 1'b1, 1'b0, ST_OK);
    lit_mode  = M_LIT;
    lit_depth = depth_q;
    lit_idle  = 1'b0;
    if (char_q == CH_LPAREN) begin
      if (depth_q >= LIMIT_D) begin
        lit_res  = mk_res(8'd0, 1'b0, 1'b1, ST_DEEP);
        lit_idle = 1'b1;
      end else begin
        lit_depth = depth_q + DEPTH_W'(1);
      end
    end else if (char_q == CH_RPAREN) begin
      lit_depth = dec_depth;
      if (dec_depth == '0) begin
        lit_res  = mk_res(8'd0, 1'b0, 1'b1, ST_OK);
        lit_idle = 1'b1;
      end
    end else if (char_q == CH_BSLASH) begin
      lit_has  = 1'b0;
      lit_mode = M_ESC;
    end
  end

  assign nib         = nibble_of(char_q);
  assign oct_next    = {oct_val_q[4:0], char_q[2:0]};
  assign oct_cnt_inc = oct_cnt_q + 2'd1;

  always_comb begin
    mode_d    = mode_q;
    depth_d   = depth_q;
    oct_val_d = oct_val_q;
    oct_cnt_d = oct_cnt_q;
    hnib_d    = hnib_q;
    go_idle   = 1'b0;
    push.push0 = 1'b0;
    push.push1 = 1'b0;
    push.res0  = mk_res(8'd0, 1'b0, 1'b0, ST_OK);
    push.res1  = mk_res(8'd0, 1'b0, 1'b0, ST_OK);

    if (le_q) begin
      go_idle = 1'b1;
      if (mode_q == M_OCT) begin
        push.push0 = 1'b1;
        push.res0  = mk_res(oct_val_q, 1'b1, 1'b0, ST_OK);
        push.push1 = 1'b1;
        push.res1  = mk_res(8'd0, 1'b0, 1'b1, ST_LINE);
      end else if (mode_q != M_IDLE) begin
        push.push0 = 1'b1;
        push.res0  = mk_res(8'd0, 1'b0, 1'b1, ST_LINE);
      end
    end else begin
      unique case (mode_q)
        M_LIT: begin
          push.push0 = lit_has;
          push.res0  = lit_res;
          mode_d     = lit_mode;
          depth_d    = lit_depth;
          go_idle    = lit_idle;
        end
        M_ESC: begin
          mode_d     = M_LIT;
          push.push0 = 1'b1;
          if (char_q == CH_B) begin
            push.res0 = mk_res(BS_BYTE, 1'b1, 1'b0, ST_OK);
          end else if (char_q == CH_F) begin
            push.res0 = mk_res(FF_BYTE, 1'b1, 1'b0, ST_OK);
          end else if (char_q == CH_N) begin
            push.res0 = mk_res(LF_BYTE, 1'b1, 1'b0, ST_OK);
          end else if (char_q == CH_R) begin
            push.res0 = mk_res(CR_BYTE, 1'b1, 1'b0, ST_OK);
          end else if (char_q == CH_T) begin
            push.res0 = mk_res(HT_BYTE, 1'b1, 1'b0, ST_OK);
          end else if (is_octal(char_q)) begin
            push.push0 = 1'b0;
            oct_val_d  = {5'd0, char_q[2:0]};
            oct_cnt_d  = 2'd1;
            mode_d     = M_OCT;
          end else begin
            push.res0 = mk_res(char_q, 1'b1, 1'b0, ST_OK);
          end
        end
        M_OCT: begin
          if (is_octal(char_q)) begin
            oct_val_d = oct_next;
            oct_cnt_d = oct_cnt_inc;
            if (oct_cnt_inc == 2'd3) begin
              push.push0 = 1'b1;
              push.res0  = mk_res(oct_next, 1'b1, 1'b0, ST_OK);
              oct_val_d  = 8'd0;
              oct_cnt_d  = 2'd0;
              mode_d     = M_LIT;
            end
          end else begin
            // Flush the collected value, then treat the character as literal.
            push.push0 = 1'b1;
            push.res0  = mk_res(oct_val_q, 1'b1, 1'b0, ST_OK);
            push.push1 = lit_has;
            push.res1  = lit_res;
            oct_val_d  = 8'd0;
            oct_cnt_d  = 2'd0;
            mode_d     = lit_mode;
            depth_d    = lit_depth;
            go_idle    = lit_idle;
          end
        end
        M_HEXH: begin
          if (!is_white(char_q)) begin
            if (char_q == CH_GT) begin
              push.push0 = 1'b1;
              push.res0  = mk_res(8'd0, 1'b0, 1'b1, ST_OK);
              go_idle    = 1'b1;
            end else if (!nib.ok) begin
              push.push0 = 1'b1;
              push.res0  = mk_res(8'd0, 1'b0, 1'b1, ST_HEX);
              go_idle    = 1'b1;
            end else begin
              hnib_d = nib.val;
              mode_d = M_HEXL;
            end
          end
        end
        M_HEXL: begin
          if (!is_white(char_q)) begin
            push.push0 = 1'b1;
            if (char_q == CH_GT) begin
              push.res0 = mk_res({hnib_q, 4'd0}, 1'b1, 1'b1, ST_OK);
              go_idle   = 1'b1;
            end else if (!nib.ok) begin
              push.res0 = mk_res(8'd0, 1'b0, 1'b1, ST_HEX);
              go_idle   = 1'b1;
            end else begin
              push.res0 = mk_res({hnib_q, nib.val}, 1'b1, 1'b0, ST_OK);
              hnib_d    = 4'd0;
              mode_d    = M_HEXH;
            end
          end
        end
        default: begin
          go_idle = 1'b1;
          if (char_q == CH_LPAREN) begin
            go_idle = 1'b0;
            mode_d  = M_LIT;
            depth_d = DEPTH_W'(1);
            oct_val_d = 8'd0;
            oct_cnt_d = 2'd0;
            hnib_d    = 4'd0;
          end else if (char_q == CH_LT) begin
            go_idle = 1'b0;
            mode_d  = M_HEXH;
            depth_d = '0;
            oct_val_d = 8'd0;
            oct_cnt_d = 2'd0;
            hnib_d    = 4'd0;
          end
        end
      endcase
    end

    if (go_idle) begin
      mode_d    = M_IDLE;
      depth_d   = '0;
      oct_val_d = 8'd0;
      oct_cnt_d = 2'd0;
      hnib_d    = 4'd0;
    end

    push.push0 = push.push0 && fire;
    push.push1 = push.push1 && fire;
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= M_IDLE;
      depth_q   <= '0;
      oct_val_q <= 8'd0;
      oct_cnt_q <= 2'd0;
      hnib_q    <= 4'd0;
    end else if (fire) begin
      mode_q    <= mode_d;
      depth_q   <= depth_d;
      oct_val_q <= oct_val_d;
      oct_cnt_q <= oct_cnt_d;
      hnib_q    <= hnib_d;
    end
  end

endmodule

// File: hw/rtl/psdec_outq.sv
// ----------------------------------------------------------------------------
// String decoder result queue
// Small register queue that takes up to two results per cycle and hands
// them out one per transaction on the result channel.
// ----------------------------------------------------------------------------
module psdec_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  psdec_pkg::push_t push_i,
  output logic             room_o,
  psdec_out_if.source      out_o
);
  import psdec_pkg::*;

  result_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              pop;
  result_t           head;

  assign pop      = out_o.valid && out_o.ready;
  assign wr_ptr_d = wr_ptr_q + QPTR_W'(push_i.push0) + QPTR_W'(push_i.push1);
  assign cnt_d    = cnt_q + QCNT_W'(push_i.push0) + QCNT_W'(push_i.push1)
                    - QCNT_W'(pop);

  // Room for two results regardless of what leaves this cycle.
  assign room_o = cnt_q <= QCNT_W'(QDEPTH - 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.push1) begin
      mem_q[wr_ptr_q + QPTR_W'(1)] <= push_i.res1;
    end
  end

  assign head             = mem_q[rd_ptr_q];
  assign out_o.valid      = cnt_q != '0;
  assign out_o.data_byte  = head.data_byte;
  assign out_o.has_byte   = head.has_byte;
  assign out_o.string_end = head.string_end;
  assign out_o.status     = head.status;

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_push_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push1 |-> push_i.push0)
    else $error("second result pushed without a first");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.push0 || push_i.push1) |-> room_o)
    else $error("result pushed without room");

  a_status_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != ST_OK) |-> out_o.string_end)
    else $error("error status on a result that does not end the string");

  a_empty_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.has_byte) |-> (out_o.data_byte == 8'd0))
    else $error("nonzero data on a result without a byte");
`endif

endmodule

// File: hw/rtl/postscript_string_decoder_unit.sv
// ----------------------------------------------------------------------------
// PostScript string decoder unit
// Decodes literal and hex strings from a character stream into bytes.
// ----------------------------------------------------------------------------
// Usage:
// The in_i channel takes one character per transaction, or a line end when
// line_end is set. The out_o channel delivers decoded bytes one per
// transaction; string_end marks the last result of a string and status
// reports how it ended.
// An accepted character is registered in the input register and decoded from
// there once the queue has room for two results; its results are written to a
// four-entry result queue, whose head is offered on the out_o channel.
// Throughput is one character per cycle while the receiver keeps up. A
// character that yields two results (a flushed octal escape followed by
// another result) fills the queue faster than it drains; the decode stage
// waits whenever the queue lacks room for two results.
// Reset empties the queue and returns the decoder to the state outside any
// string. When the receiver stalls, results stay in the queue and the input
// keeps being accepted until the queue lacks room for two results and a
// character waits in the input register.
// ----------------------------------------------------------------------------
module postscript_string_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  psdec_in_if.sink    in_i,
  psdec_out_if.source out_o
);
  import psdec_pkg::*;

  push_t push;
  logic  room;

  psdec_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .room_i (room),
    .push_o (push)
  );

  psdec_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule
